/* rtl/core/sha1s_pkg.sv */
// Package for the SHA-1 stream hasher: shared types, state encodings and constants.
// No dependencies; the front end, job queue, back end, top level and scoreboard import it.
package sha1s_pkg;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam logic [5:0]  LAST_POS = 6'd63;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

  typedef enum logic {F_ACCEPT, F_PAD} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_LOAD, B_ROUND, B_ADD, B_EMIT} back_state_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic bank;
    logic last_block;
  } job_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

endpackage

/* rtl/core/sha1s_in_if.sv */
// Input channel of the SHA-1 stream hasher: at most one message byte per transfer.
// Standalone interface; no dependencies.
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

/* rtl/core/sha1s_out_if.sv */
// Output channel of the SHA-1 stream hasher: one digest word per transfer.
// Standalone interface; no dependencies.
interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/core/sha1s_front.sv */
// Front end: accepts bytes, packs them into words of a two-bank block store,
// generates padding and posts one job per full block. Uses sha1s_pkg, sha1s_in_if.
module sha1s_front (
  input  logic                clk,
  input  logic                rst,
  sha1s_in_if.sink            msg,
  input  sha1s_pkg::release_t rel,
  output sha1s_pkg::mem_wr_t  mem_wr,
  output logic                push,
  output sha1s_pkg::job_t     push_job
);
  import sha1s_pkg::*;

  front_state_t state, state_next;
  logic         bank;
  logic [5:0]   fill;
  logic [23:0]  acc;
  logic [63:0]  message_bits;
  logic [63:0]  len_bits;
  logic         pad_first;
  logic         len_phase;
  logic [1:0]   busy, busy_next;

  logic         accept;
  logic         put_en;
  logic [7:0]   put_byte;
  logic         is_len;

  always_comb begin
    msg.ready = 1'b0;
    accept    = 1'b0;
    put_en    = 1'b0;
    put_byte  = msg.data_byte;
    is_len    = 1'b0;
    unique case (state)
      F_ACCEPT: begin
        msg.ready = !busy[bank];
        accept    = msg.valid && !busy[bank];
        put_en    = accept && msg.has_byte;
      end
      F_PAD: begin
        put_en = !busy[bank];
        is_len = !pad_first && (len_phase || fill == LEN_POS);
        if (pad_first) begin
          put_byte = PAD_MARK;
        end else if (is_len) begin
          put_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
        end else begin
          put_byte = 8'h00;
        end
      end
      default: begin
        msg.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_ACCEPT: if (accept && msg.end_of_message) state_next = F_PAD;
      F_PAD:    if (put_en && is_len && fill == LAST_POS) state_next = F_ACCEPT;
      default:  state_next = F_ACCEPT;
    endcase
  end

  assign push            = put_en && fill == LAST_POS;
  assign push_job.bank   = bank;
  assign push_job.last_block = (state == F_PAD) && is_len;

  assign mem_wr.en   = put_en && fill[1:0] == 2'b11;
  assign mem_wr.addr = {bank, fill[5:2]};
  assign mem_wr.data = {acc, put_byte};

  always_comb begin
    busy_next = busy;
    if (rel.en) busy_next[rel.bank] = 1'b0;
    if (push) busy_next[bank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_ACCEPT;
      bank         <= 1'b0;
      fill         <= '0;
      message_bits <= '0;
      pad_first    <= 1'b0;
      len_phase    <= 1'b0;
      busy         <= '0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      if (put_en) begin
        fill <= fill + 6'd1;
        acc  <= {acc[15:0], put_byte};
        if (fill == LAST_POS) bank <= ~bank;
      end
      if (accept) begin
        if (msg.end_of_message) begin
          len_bits     <= message_bits + (msg.has_byte ? 64'd8 : 64'd0);
          message_bits <= '0;
          pad_first    <= 1'b1;
          len_phase    <= 1'b0;
        end else if (msg.has_byte) begin
          message_bits <= message_bits + 64'd8;
        end
      end
      if (state == F_PAD && put_en) begin
        pad_first <= 1'b0;
        if (is_len) len_phase <= (fill != LAST_POS);
      end
    end
  end

endmodule

/* rtl/core/sha1s_job_queue.sv */
// Two-entry job queue between the front end and the round engine.
// Uses sha1s_pkg for the job type.
module sha1s_job_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sha1s_pkg::job_t push_job,
  input  logic            pop,
  output logic            not_empty,
  output sha1s_pkg::job_t head
);
  import sha1s_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != 2'd2)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("job queue count out of range");

endmodule

/* rtl/core/sha1s_back.sv */
// Back end: holds the two-bank block store, runs the 80 SHA-1 rounds one per
// cycle and sends the digest words. Uses sha1s_pkg, sha1s_out_if.
module sha1s_back (
  input  logic                clk,
  input  logic                rst,
  input  sha1s_pkg::mem_wr_t  mem_wr,
  input  logic                job_ready,
  input  sha1s_pkg::job_t     job_head,
  output logic                pop,
  output sha1s_pkg::release_t rel,
  sha1s_out_if.source         digest
);
  import sha1s_pkg::*;

  logic [31:0] store [32];
  logic [31:0] rdata;
  logic [4:0]  rd_addr;

  back_state_t state, state_next;
  job_t        job;
  logic [6:0]  round;
  logic [2:0]  emit_idx;
  logic [31:0] chain [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];

  logic [31:0] sched_word, mix, f, k, t;
  logic        load_out;

  always_ff @(posedge clk) begin
    if (mem_wr.en) store[mem_wr.addr] <= mem_wr.data;
    rdata <= store[rd_addr];
  end

  always_comb begin
    mix        = w[13] ^ w[8] ^ w[2] ^ w[0];
    sched_word = (round < 7'd16) ? rdata : {mix[30:0], mix[31]};
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + sched_word;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (job_ready) state_next = B_LOAD;
      B_LOAD:  state_next = B_ROUND;
      B_ROUND: if (round == LAST_ROUND) state_next = B_ADD;
      B_ADD:   state_next = job.last_block ? B_EMIT : B_IDLE;
      B_EMIT:  if (load_out && emit_idx == LAST_WORD_IDX) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rel.en   = 1'b0;
    rel.bank = job.bank;
    rd_addr  = {job.bank, 4'd0};
    load_out = 1'b0;
    unique case (state)
      B_IDLE:  pop = job_ready;
      B_LOAD:  rd_addr = {job.bank, 4'd0};
      B_ROUND: rd_addr = {job.bank, round[3:0] + 4'd1};
      B_ADD:   rel.en = 1'b1;
      B_EMIT:  load_out = !digest.valid || digest.ready;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      digest.valid <= 1'b0;
      emit_idx     <= '0;
      round        <= '0;
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
    end else begin
      state <= state_next;
      if (load_out) begin
        digest.valid <= 1'b1;
      end else if (digest.ready) begin
        digest.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_ready) job <= job_head;
        end
        B_LOAD: begin
          round <= '0;
          a <= chain[0];
          b <= chain[1];
          c <= chain[2];
          d <= chain[3];
          e <= chain[4];
        end
        B_ROUND: begin
          round <= round + 7'd1;
          e <= d;
          d <= c;
          c <= {b[1:0], b[31:2]};
          b <= a;
          a <= t;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= sched_word;
        end
        B_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          emit_idx <= '0;
        end
        B_EMIT: begin
          if (load_out) begin
            digest.digest_word <= chain[emit_idx];
            digest.word_index  <= emit_idx;
            digest.last_word   <= emit_idx == LAST_WORD_IDX;
            emit_idx           <= emit_idx + 3'd1;
            if (emit_idx == LAST_WORD_IDX) begin
              for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
            end
          end
        end
        default: begin
          round <= '0;
        end
      endcase
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> digest.word_index <= LAST_WORD_IDX)
    else $error("digest word index out of range");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> digest.last_word == (digest.word_index == LAST_WORD_IDX))
    else $error("last word flag does not match index");
  a_round_done: assert property (@(posedge clk) disable iff (rst)
    state == B_ADD |-> $past(state) == B_ROUND && $past(round) == LAST_ROUND)
    else $error("block finished before the last round");

endmodule

/* rtl/core/sha1_stream_hasher.sv */
// SHA-1 stream hasher top level. Byte transfers are accepted while the block-store
// bank being filled is free. Each 64-byte block passes through the round engine in order
// (queue pop, store read, 80 rounds, chaining add) while the front end may fill the other
// bank. End of message adds 9 to 72 bytes of byte-wise padding, one or two
// blocks and five digest transfers. Synchronous rst restores the initial chaining words and
// clears the fill and bit counts, the bank flags, the job queue and both state machines.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  sha1s_in_if.sink    msg,
  sha1s_out_if.source digest
);
  import sha1s_pkg::*;

  mem_wr_t  mem_wr;
  logic     push;
  job_t     push_job;
  logic     pop;
  logic     job_ready;
  job_t     job_head;
  release_t rel;

  sha1s_front u_front (
    .clk      (clk),
    .rst      (rst),
    .msg      (msg),
    .rel      (rel),
    .mem_wr   (mem_wr),
    .push     (push),
    .push_job (push_job)
  );

  sha1s_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (job_ready),
    .head      (job_head)
  );

  sha1s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mem_wr    (mem_wr),
    .job_ready (job_ready),
    .job_head  (job_head),
    .pop       (pop),
    .rel       (rel),
    .digest    (digest)
  );

endmodule

/* verif/sha1_digest_board_pkg.sv */
// Scoreboard for the SHA-1 stream hasher: a bit-exact digest predictor and the
// queue of digest words it expects. Depends on sha1s_pkg for the SHA-1 constants.
package sha1_digest_board_pkg;
  import sha1s_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_entry_t;

  class sha1_digest_board;
    logic [31:0]   chain[5];
    logic [7:0]    block_bytes[64];
    int            fill;
    logic [63:0]   msg_bits;
    digest_entry_t pending_words[$];
    int            mismatches;

    function new();
      chain = H_INIT;
      fill = 0;
      msg_bits = '0;
      mismatches = 0;
      foreach (block_bytes[i]) block_bytes[i] = '0;
    endfunction

    function void compress_block();
      logic [31:0] sched[80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int r = 0; r < 16; r++) begin
        sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
      end
      for (int r = 16; r < 80; r++) begin
        x = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
        sched[r] = {x[30:0], x[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_R0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_R1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_R2;
        end else begin
          f = b ^ c ^ d;
          k = K_R3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[r];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void push_byte(logic [7:0] v);
      block_bytes[fill] = v;
      fill++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    endfunction

    function void absorb_item(logic [7:0] data_byte, logic has_byte, logic end_of_message);
      logic [63:0] length_bits;
      if (has_byte) begin
        msg_bits += 64'd8;
        push_byte(data_byte);
      end
      if (!end_of_message) return;
      length_bits = msg_bits;
      push_byte(PAD_MARK);
      while (fill != int'(LEN_POS)) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(length_bits[63-8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        pending_words.push_back('{chain[i], 3'(i), 3'(i) == LAST_WORD_IDX});
      end
      chain = H_INIT;
      fill = 0;
      msg_bits = '0;
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_entry_t exp_entry;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected digest transfer: expected none, actual word %h idx %0d",
                 $time, word, idx);
        mismatches++;
        return;
      end
      exp_entry = pending_words.pop_front();
      if (word !== exp_entry.word) begin
        $display("%0t: digest_word mismatch: expected %h, actual %h",
                 $time, exp_entry.word, word);
        mismatches++;
      end
      if (idx !== exp_entry.idx) begin
        $display("%0t: word_index mismatch: expected %0d, actual %0d",
                 $time, exp_entry.idx, idx);
        mismatches++;
      end
      if (last !== exp_entry.last) begin
        $display("%0t: last_word mismatch: expected %b, actual %b",
                 $time, exp_entry.last, last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

endpackage

/* verif/tb_sha1_stream_hasher.sv */
// Top-level testbench for sha1_stream_hasher: directed and random messages with
// random stalls on both channels. Depends on sha1s_pkg, both channel interfaces
// and sha1_digest_board_pkg.
module tb_sha1_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1_digest_board_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 1500;
  localparam int DRAIN_CYCLES = 400;
  localparam int ITEM_TARGET = 410;

  logic clk;
  logic rst;
  logic hold_req;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   items_sent;
  int   quiet_cycles;

  sha1s_in_if  msg_if ();
  sha1s_out_if dig_if ();

  sha1_digest_board board = new();

  sha1_stream_hasher DUT (
    .clk   (clk),
    .rst   (rst),
    .msg   (msg_if.sink),
    .digest(dig_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && msg_if.valid && msg_if.ready) begin
      board.absorb_item(msg_if.data_byte, msg_if.has_byte, msg_if.end_of_message);
    end
    if (!rst && dig_if.valid && dig_if.ready) begin
      board.check_word(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : digest_sink
    bit held;
    held = 1'b0;
    dig_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        dig_if.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end
      dig_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk);
    end
    msg_if.valid <= 1'b1;
    msg_if.data_byte <= b;
    msg_if.has_byte <= has;
    msg_if.end_of_message <= eom;
    do @(posedge clk); while (!msg_if.ready);
    items_sent++;
  endtask

  task automatic send_message(input int len, input bit bare_end, input bit with_noise);
    for (int i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(99) < 5) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1, !bare_end && i == len - 1);
    end
    if (bare_end || len == 0) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_drained();
    msg_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int pick_length();
    int edges[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return $urandom_range(0, 8);
    if (sel < 65) return $urandom_range(9, 54);
    return edges[$urandom_range(9)];
  endfunction

  initial begin : stimulus
    rst <= 1'b1;
    hold_req <= 1'b0;
    msg_if.valid <= 1'b0;
    msg_if.data_byte <= '0;
    msg_if.has_byte <= 1'b0;
    msg_if.end_of_message <= 1'b0;
    src_idle_pct = 11;
    sink_idle_pct = 65;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty message, "abc", ignored items, byte extremes and bare end markers.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);

    // The digest side stalls for a long time while messages keep arriving.
    hold_req <= 1'b1;
    for (int m = 0; m < 3; m++) send_message($urandom_range(60, 70), 1'b0, 1'b0);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        src_idle_pct = 11;
        sink_idle_pct = 65;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        src_idle_pct = 65;
        sink_idle_pct = 11;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      send_message(pick_length(), $urandom_range(1), 1'b1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
